/* rtl/mbps_pkg.sv */
`default_nettype none

package mbps_pkg;

	localparam int BYTE_W = 8;
	localparam int ADDR_W = 64;
	localparam int LEN_W  = 9;
	localparam int IDX_W  = 8;

	// Item kinds carried on the kind field.
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_DATA = 1'b1;

endpackage

`default_nettype wire

/* rtl/masked_byte_pattern_scan.sv */
// Wildcard byte pattern search over a stream of addressed bytes.
// Input channel (in_valid/in_ready) carries either a pattern load word
// (kind = load: pattern_index, pattern_byte, pattern_care) or a data word
// (kind = data: data_byte, data_address, region_start). The output channel
// (out_valid/out_ready) carries match_address, the address of the first
// byte of each match; overlapping matches are all reported.
// cfg_we/cfg_wdata write pattern_length; the user must write it only while idle; the block does not enforce this.
// Throughput is one word per cycle while no result waits unaccepted. A result
// reaches the output through its registers: the input register takes the word,
// the window update with the alignment shifter loads the aligned stage, then
// the parallel compare loads the output register. The alignment shifter and
// the compare of all positions set the cycle time.
// Reset clears the window fill count, empties the pipeline and sets the
// length to one; pattern entries hold nothing until loaded.
// The whole pipeline holds and in_ready drops only while a result waits
// unaccepted, not merely while the receiver stalls.
// A data word with region_start set empties the window before it enters.
`default_nettype none

module masked_byte_pattern_scan #(
	parameter int MAX_PATTERN = 256
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [mbps_pkg::LEN_W-1:0]    cfg_wdata,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          kind,
	input  wire [mbps_pkg::IDX_W-1:0]    pattern_index,
	input  wire [mbps_pkg::BYTE_W-1:0]   pattern_byte,
	input  wire                          pattern_care,
	input  wire [mbps_pkg::BYTE_W-1:0]   data_byte,
	input  wire [mbps_pkg::ADDR_W-1:0]   data_address,
	input  wire                          region_start,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [mbps_pkg::ADDR_W-1:0]  match_address
);
	import mbps_pkg::*;

	localparam int LW  = $clog2(MAX_PATTERN + 1);
	localparam int WVW = MAX_PATTERN * BYTE_W;

	logic [LEN_W-1:0] len_q;
	logic [LW-1:0]    eff_len;
	logic             adv;

	// Input register
	logic               valid_s1;
	logic               kind_s1;
	logic [IDX_W-1:0]   pidx_s1;
	logic [BYTE_W-1:0]  pbyte_s1;
	logic               pcare_s1;
	logic [BYTE_W-1:0]  dbyte_s1;
	logic [ADDR_W-1:0]  daddr_s1;
	logic               region_s1;

	// Window state and pattern stores
	logic [WVW-1:0]     window_q;
	logic [LW-1:0]      fill_q;
	logic [BYTE_W-1:0]  pat_q [MAX_PATTERN];
	logic               care_q [MAX_PATTERN];

	// Aligned stage
	logic               valid_s2;
	logic               ok_s2;
	logic [ADDR_W-1:0]  addr_s2;
	logic [WVW-1:0]     aligned_s2;

	logic               out_valid_q;
	logic [ADDR_W-1:0]  match_address_q;

	logic [WVW-1:0]     win_new;
	logic [WVW-1:0]     rev_win;
	logic [LW-1:0]      fill_new;
	logic [LW-1:0]      shamt;
	logic               data_s1;
	logic               load_s1;
	logic               all_hit;

	assign eff_len = (32'(len_q) > MAX_PATTERN) ? LW'(MAX_PATTERN) : LW'(len_q);
	assign adv     = !out_valid_q || out_ready;
	assign data_s1 = valid_s1 && (kind_s1 == KIND_DATA);
	assign load_s1 = valid_s1 && (kind_s1 == KIND_LOAD);

	assign in_ready      = adv;
	assign out_valid     = out_valid_q;
	assign match_address = match_address_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	// The newest byte sits at the bottom of the window, age zero.
	always_comb begin
		win_new  = ((region_s1 ? '0 : window_q) << BYTE_W) | WVW'(dbyte_s1);
		fill_new = region_s1 ? LW'(1)
			: ((32'(fill_q) < MAX_PATTERN) ? fill_q + LW'(1) : fill_q);
		for (int k = 0; k < MAX_PATTERN; k++) begin
			rev_win[k*BYTE_W +: BYTE_W] = win_new[(MAX_PATTERN-1-k)*BYTE_W +: BYTE_W];
		end
		shamt = LW'(MAX_PATTERN - 32'(eff_len));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			kind_s1   <= kind;
			pidx_s1   <= pattern_index;
			pbyte_s1  <= pattern_byte;
			pcare_s1  <= pattern_care;
			dbyte_s1  <= data_byte;
			daddr_s1  <= data_address;
			region_s1 <= region_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (adv && data_s1) begin
			fill_q <= fill_new;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && data_s1) begin
			window_q <= win_new;
		end
	end

	// A load beyond the store depth matches no entry and is dropped.
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (adv && load_s1 && (32'(pidx_s1) == j)) begin
				pat_q[j]  <= pbyte_s1;
				care_q[j] <= pcare_s1;
			end
		end
	end

	// Pattern position j lines up with the byte of age len-1-j, which is
	// the reversed window shifted down by MAX_PATTERN-len positions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && data_s1) begin
			aligned_s2 <= rev_win >> (32'(shamt) << 3);
			ok_s2      <= (eff_len != '0) && (fill_new >= eff_len);
			addr_s2    <= daddr_s1 - (ADDR_W'(eff_len) - ADDR_W'(1));
		end
	end

	always_comb begin
		all_hit = ok_s2;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if ((LW'(j) < eff_len) && care_q[j]
				&& (aligned_s2[j*BYTE_W +: BYTE_W] != pat_q[j])) begin
				all_hit = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2 && all_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			match_address_q <= addr_s2;
		end
	end

endmodule

`default_nettype wire

/* rtl/mbps_checker.sv */
`default_nettype none

module mbps_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_ready,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire [mbps_pkg::ADDR_W-1:0]   match_address
);
	import mbps_pkg::*;

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// A stalled result holds its address.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_address))
		else $error("result changed while stalled");

	// Input back-pressure comes only from an unaccepted result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	// A spell with no accepted word and a ready receiver drains the pipeline.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!in_acc, 1) && $past(!in_acc, 2) && $past(!in_acc, 3)
		&& $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
		|-> !out_valid)
		else $error("result appeared with no word to cause it");

endmodule

bind masked_byte_pattern_scan mbps_checker u_mbps_checker (.*);

`default_nettype wire
